// File: hdl/rfd_pkg.sv
`timescale 1ns / 1ps
package rfd_pkg;

  localparam int STORE_BYTES = 1024;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int CNT_W       = $clog2(STORE_BYTES + 1);
  localparam int SUM_W       = CNT_W + 1;
  localparam int LEN_W       = 16;
  localparam int CMP_W       = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int BYTE_W      = 8;
  localparam int CFG_LEN_W   = 11;
  localparam int WORD_W      = 16;

  localparam int NUM_FIELD_BYTES = 7;
  localparam int FLD_IDX_W       = 3;

  localparam logic [BYTE_W-1:0]    START_MARK  = 8'hFF;
  localparam logic [LEN_W-1:0]     MIN_FRAME   = 16'd11;
  localparam logic [CNT_W-1:0]     HDR_BYTES   = CNT_W'(3);
  localparam logic [CFG_LEN_W-1:0] SHORT_RESET = 11'd11;
  localparam logic [CFG_LEN_W-1:0] LONG_RESET  = 11'd1024;
  localparam logic [BYTE_W-1:0]    STOP_RESET  = 8'd0;

  // Byte offsets inside a frame.
  localparam logic [3:0] OFF_LEN_HI      = 4'd1;
  localparam logic [3:0] OFF_LEN_LO      = 4'd2;
  localparam logic [3:0] OFF_FIELD_FIRST = 4'd3;
  localparam logic [3:0] OFF_FIELD_LAST  = 4'd9;

  typedef enum logic [1:0] {
    CFG_SHORT_LEN = 2'd0,
    CFG_LONG_LEN  = 2'd1,
    CFG_STOP      = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    RD_SCAN,
    RD_FIXED,
    RD_STOP
  } rd_src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN_REQ,
    ST_SCAN_CHK,
    ST_LEN,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_LEN_CHK,
    ST_STOP_CHK,
    ST_FIELD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                 wr_byte;
    logic                 rd_en;
    rd_src_t              rd_src;
    logic [3:0]           fix_off;
    logic                 s_clr;
    logic                 s_inc;
    logic                 drop_s;
    logic                 drop_one;
    logic                 clear_store;
    logic                 cap_hi;
    logic                 cap_len;
    logic                 cap_field;
    logic [FLD_IDX_W-1:0] fld_slot;
    logic                 load_out;
  } cmd_t;

  typedef struct packed {
    logic fill_ge_short;
    logic scan_end;
    logic rd_is_start;
    logic fill_lt3;
    logic len_bad;
    logic fill_lt_len;
    logic stop_match;
    logic out_free;
  } stat_t;

  // Folds head plus offset back into the circular store. Both terms are
  // at most the store size, so one compare and subtract is enough.
  function automatic logic [ADDR_W-1:0] wrap_addr(input logic [SUM_W-1:0] sum);
    logic [SUM_W-1:0] res;
    res = sum;
    if (sum >= SUM_W'(STORE_BYTES)) begin
      res = sum - SUM_W'(STORE_BYTES);
    end
    return res[ADDR_W-1:0];
  endfunction

endpackage

// File: hdl/rfd_ctrl.sv
`timescale 1ns / 1ps
module rfd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rfd_pkg::stat_t stat,
  output rfd_pkg::cmd_t  cmd
);
  import rfd_pkg::*;

  state_t     state_r, state_nxt;
  logic [3:0] fld_r, fld_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fld_r   <= OFF_FIELD_FIRST;
    end else begin
      state_r <= state_nxt;
      fld_r   <= fld_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    fld_nxt   = fld_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = stat.fill_ge_short ? ST_SCAN_REQ : ST_IDLE;
      end
      ST_SCAN_REQ: begin
        state_nxt = stat.scan_end ? ST_IDLE : ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        state_nxt = stat.rd_is_start ? ST_LEN : ST_SCAN_REQ;
      end
      ST_LEN: begin
        state_nxt = stat.fill_lt3 ? ST_IDLE : ST_LEN_HI;
      end
      ST_LEN_HI: state_nxt = ST_LEN_LO;
      ST_LEN_LO: state_nxt = ST_LEN_CHK;
      ST_LEN_CHK: begin
        if (stat.len_bad) state_nxt = ST_CHECK;
        else if (stat.fill_lt_len) state_nxt = ST_IDLE;
        else state_nxt = ST_STOP_CHK;
      end
      ST_STOP_CHK: begin
        if (stat.stop_match) begin
          state_nxt = ST_FIELD;
          fld_nxt   = OFF_FIELD_FIRST;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_FIELD: begin
        if (fld_r == OFF_FIELD_LAST) begin
          state_nxt = ST_EMIT;
        end else begin
          fld_nxt = fld_r + 4'd1;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.rd_src = RD_SCAN;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.wr_byte = in_valid;
      end
      ST_CHECK: cmd.s_clr = 1'b1;
      ST_SCAN_REQ: begin
        if (stat.scan_end) begin
          cmd.clear_store = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_SCAN;
        end
      end
      ST_SCAN_CHK: begin
        if (stat.rd_is_start) cmd.drop_s = 1'b1;
        else cmd.s_inc = 1'b1;
      end
      ST_LEN: begin
        if (!stat.fill_lt3) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_src  = RD_FIXED;
          cmd.fix_off = OFF_LEN_HI;
        end
      end
      ST_LEN_HI: begin
        cmd.cap_hi  = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_src  = RD_FIXED;
        cmd.fix_off = OFF_LEN_LO;
      end
      ST_LEN_LO: cmd.cap_len = 1'b1;
      ST_LEN_CHK: begin
        if (stat.len_bad) begin
          cmd.drop_one = 1'b1;
        end else if (!stat.fill_lt_len) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_STOP;
        end
      end
      ST_STOP_CHK: begin
        if (stat.stop_match) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_src  = RD_FIXED;
          cmd.fix_off = OFF_FIELD_FIRST;
        end else begin
          cmd.drop_one = 1'b1;
        end
      end
      ST_FIELD: begin
        cmd.cap_field = 1'b1;
        cmd.fld_slot  = FLD_IDX_W'(fld_r - OFF_FIELD_FIRST);
        if (fld_r != OFF_FIELD_LAST) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_src  = RD_FIXED;
          cmd.fix_off = fld_r + 4'd1;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out    = 1'b1;
          cmd.clear_store = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/rfd_datapath.sv
`timescale 1ns / 1ps
module rfd_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rfd_pkg::cmd_t                    cmd,
  output rfd_pkg::stat_t                   stat,
  input  logic [rfd_pkg::BYTE_W-1:0]       in_data_byte,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [rfd_pkg::CFG_LEN_W-1:0]    cfg_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rfd_pkg::CFG_LEN_W-1:0]    out_frame_length,
  output logic [rfd_pkg::WORD_W-1:0]       out_min_raw,
  output logic [rfd_pkg::WORD_W-1:0]       out_max_raw,
  output logic [rfd_pkg::WORD_W-1:0]       out_avg_raw,
  output logic                             out_image_present
);
  import rfd_pkg::*;

  logic [BYTE_W-1:0]    mem [0:STORE_BYTES-1];
  logic [BYTE_W-1:0]    rd_data_r;

  logic [ADDR_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]     fill_r, fill_nxt;
  logic [CNT_W-1:0]     s_r, s_nxt;
  logic [LEN_W-1:0]     len_r;
  logic [BYTE_W-1:0]    len_hi_r;
  logic [BYTE_W-1:0]    field_r [0:NUM_FIELD_BYTES-1];

  logic [CFG_LEN_W-1:0] short_r, long_r;
  logic [BYTE_W-1:0]    stop_r;

  logic                 out_valid_r;
  logic [CFG_LEN_W-1:0] out_len_r;
  logic [WORD_W-1:0]    out_min_r, out_max_r, out_avg_r;
  logic                 out_img_r;

  logic [ADDR_W-1:0]    head_plus1, wr_addr, rd_addr;
  logic [CNT_W-1:0]     rd_off;
  logic                 store_full;

  assign store_full = (fill_r == CNT_W'(STORE_BYTES));
  assign head_plus1 = wrap_addr(SUM_W'(head_r) + SUM_W'(1));
  // When the store is full this lands on the oldest byte, which is dropped.
  assign wr_addr    = wrap_addr(SUM_W'(head_r) + SUM_W'(fill_r));

  always_comb begin
    case (cmd.rd_src)
      RD_SCAN:  rd_off = s_r;
      RD_FIXED: rd_off = CNT_W'(cmd.fix_off);
      RD_STOP:  rd_off = CNT_W'(len_r - 16'd1);
      default:  rd_off = s_r;
    endcase
  end

  assign rd_addr = wrap_addr(SUM_W'(head_r) + SUM_W'(rd_off));

  always_ff @(posedge clk) begin
    if (cmd.wr_byte) mem[wr_addr] <= in_data_byte;
    if (cmd.rd_en) rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (cmd.clear_store) begin
      head_nxt = '0;
      fill_nxt = '0;
    end else if (cmd.wr_byte) begin
      if (store_full) head_nxt = head_plus1;
      else fill_nxt = fill_r + CNT_W'(1);
    end else if (cmd.drop_s) begin
      head_nxt = wrap_addr(SUM_W'(head_r) + SUM_W'(s_r));
      fill_nxt = fill_r - s_r;
    end else if (cmd.drop_one) begin
      head_nxt = head_plus1;
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_comb begin
    s_nxt = s_r;
    if (cmd.s_clr) s_nxt = '0;
    else if (cmd.s_inc) s_nxt = s_r + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
      s_r    <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
      s_r    <= s_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_hi) len_hi_r <= rd_data_r;
    if (cmd.cap_len) len_r <= {len_hi_r, rd_data_r};
    if (cmd.cap_field) field_r[cmd.fld_slot] <= rd_data_r;
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_r <= SHORT_RESET;
      long_r  <= LONG_RESET;
      stop_r  <= STOP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SHORT_LEN: short_r <= cfg_data;
        CFG_LONG_LEN:  long_r  <= cfg_data;
        CFG_STOP:      stop_r  <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  assign stat.fill_ge_short = CMP_W'(fill_r) >= CMP_W'(short_r);
  assign stat.scan_end      = (s_r == fill_r);
  assign stat.rd_is_start   = (rd_data_r == START_MARK);
  assign stat.fill_lt3      = (fill_r < HDR_BYTES);
  // A declared length too short to hold the header and stop byte is bad
  // even when a register holds that value.
  assign stat.len_bad       = (len_r < MIN_FRAME) ||
                              ((len_r != LEN_W'(short_r)) && (len_r != LEN_W'(long_r)));
  assign stat.fill_lt_len   = CMP_W'(fill_r) < CMP_W'(len_r);
  assign stat.stop_match    = (rd_data_r == stop_r);
  assign stat.out_free      = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_len_r <= len_r[CFG_LEN_W-1:0];
      out_min_r <= {field_r[0], field_r[1]};
      out_max_r <= {field_r[2], field_r[3]};
      out_avg_r <= {field_r[4], field_r[5]};
      out_img_r <= (field_r[6] != '0);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_length  = out_len_r;
  assign out_min_raw       = out_min_r;
  assign out_max_raw       = out_max_r;
  assign out_avg_raw       = out_avg_r;
  assign out_image_present = out_img_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(STORE_BYTES))
    else $error("fill count beyond store size");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    SUM_W'(head_r) < SUM_W'(STORE_BYTES))
    else $error("head pointer outside store");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid_r && out_stall))
    else $error("pending result overwritten");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_store |=> (fill_r == '0) && (head_r == '0))
    else $error("store not emptied after clear");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_en && (cmd.rd_src == RD_SCAN)) |-> (s_r < fill_r))
    else $error("scan read beyond stored bytes");

endmodule

// File: hdl/resync_frame_deframer_core.sv
`timescale 1ns / 1ps
// Byte deframer with resynchronization. Received bytes enter on the in_
// channel (in_valid / in_stall) one byte at a time and are kept in a
// 1024-byte circular store. A frame is 0xFF, a big-endian length, header
// words and a stop byte; each valid frame yields one word on the out_
// channel carrying the length, the min, max and average raw words and the
// image flag, after which the store is emptied.
// The cfg_ port writes the short length, long length and stop byte
// (indexes 0, 1, 2); cfg_ready is always high. Write it only while idle.
// The controller takes no byte while it works: in_stall is high outside
// the idle state. Once the store holds at least the short length, the
// controller walks the stored bytes through the single store read port,
// looking for 0xFF, then fetches and checks the length, the stop byte and
// the header fields. A dropped 0xFF restarts the walk. After the stop
// byte, the check, scan, length, stop and field states run before the
// emit state loads the result once the output register is free.
// Reset empties the store and loads the register defaults; no clearing
// pass is needed. A result waits in the output register while the
// receiver stalls and bytes keep being accepted; only a further complete
// frame holds in_stall high until the earlier result has been taken.
module resync_frame_deframer_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [rfd_pkg::BYTE_W-1:0]       in_data_byte,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [rfd_pkg::CFG_LEN_W-1:0]    cfg_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rfd_pkg::CFG_LEN_W-1:0]    out_frame_length,
  output logic [rfd_pkg::WORD_W-1:0]       out_min_raw,
  output logic [rfd_pkg::WORD_W-1:0]       out_max_raw,
  output logic [rfd_pkg::WORD_W-1:0]       out_avg_raw,
  output logic                             out_image_present
);
  import rfd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rfd_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_data_byte      (in_data_byte),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_length  (out_frame_length),
    .out_min_raw       (out_min_raw),
    .out_max_raw       (out_max_raw),
    .out_avg_raw       (out_avg_raw),
    .out_image_present (out_image_present)
  );

endmodule

// File: sim/resync_frame_deframer_core_test.sv
`timescale 1ns / 1ps
module resync_frame_deframer_core_test;
  import rfd_pkg::*;

  localparam int SETTLE_CYCLES = 20000;
  localparam int LIMIT_CYCLES  = 3000000;
  localparam int MIX_BYTES     = 100;
  localparam int MAX_MIX_LEN   = 96;
  localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct packed {
    logic [CFG_LEN_W-1:0] frame_length;
    logic [WORD_W-1:0]    min_raw;
    logic [WORD_W-1:0]    max_raw;
    logic [WORD_W-1:0]    avg_raw;
    logic                 image_present;
  } frame_fields_t;

  class deframe_scoreboard;
    logic [BYTE_W-1:0] ring [STORE_BYTES];
    int unsigned head;
    int unsigned fill;
    int unsigned short_len;
    int unsigned long_len;
    logic [BYTE_W-1:0] stop_val;
    frame_fields_t expected_frames [$];
    int errors;

    function new();
      head      = 0;
      fill      = 0;
      short_len = SHORT_RESET;
      long_len  = LONG_RESET;
      stop_val  = STOP_RESET;
      errors    = 0;
    endfunction

    function logic [BYTE_W-1:0] peek(int unsigned k);
      return ring[(head + k) % STORE_BYTES];
    endfunction

    function void drop(int unsigned n);
      if (n > fill) n = fill;
      head = (head + n) % STORE_BYTES;
      fill = fill - n;
    endfunction

    function void set_reg(logic [1:0] idx, logic [CFG_LEN_W-1:0] data);
      case (idx)
        CFG_SHORT_LEN: short_len = data;
        CFG_LONG_LEN:  long_len  = data;
        CFG_STOP:      stop_val  = data[BYTE_W-1:0];
        default: ;
      endcase
    endfunction

    // Append one byte, then resynchronize until the store either waits for
    // more bytes, is emptied, or yields a complete frame.
    function void absorb_byte(logic [BYTE_W-1:0] b);
      int unsigned s;
      logic [LEN_W-1:0] len;
      frame_fields_t f;
      if (fill >= STORE_BYTES) drop(1);
      ring[(head + fill) % STORE_BYTES] = b;
      fill++;
      while (fill >= short_len) begin
        s = 0;
        while (s < fill && peek(s) != START_MARK) s++;
        if (s == fill) begin
          head = 0;
          fill = 0;
          break;
        end
        drop(s);
        if (fill < 3) break;
        len = {peek(1), peek(2)};
        if (len < MIN_FRAME || (len != short_len && len != long_len)) begin
          drop(1);
          continue;
        end
        if (fill < len) break;
        if (peek(len - 1) == stop_val) begin
          f.frame_length  = len[CFG_LEN_W-1:0];
          f.min_raw       = {peek(3), peek(4)};
          f.max_raw       = {peek(5), peek(6)};
          f.avg_raw       = {peek(7), peek(8)};
          f.image_present = (peek(9) != 8'h00);
          expected_frames.push_back(f);
          head = 0;
          fill = 0;
          return;
        end
        drop(1);
      end
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(frame_fields_t got);
      frame_fields_t want;
      if (expected_frames.size() == 0) begin
        report($sformatf("unexpected frame word len=%0d", got.frame_length));
        return;
      end
      want = expected_frames.pop_front();
      if (got.frame_length !== want.frame_length || got.min_raw !== want.min_raw ||
          got.max_raw !== want.max_raw || got.avg_raw !== want.avg_raw ||
          got.image_present !== want.image_present) begin
        report($sformatf("got len=%0d min=%h max=%h avg=%h img=%b, want %0d %h %h %h %b",
                         got.frame_length, got.min_raw, got.max_raw, got.avg_raw,
                         got.image_present, want.frame_length, want.min_raw,
                         want.max_raw, want.avg_raw, want.image_present));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_data_byte;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [1:0]           cfg_index;
  logic [CFG_LEN_W-1:0] cfg_data;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CFG_LEN_W-1:0] out_frame_length;
  logic [WORD_W-1:0]    out_min_raw;
  logic [WORD_W-1:0]    out_max_raw;
  logic [WORD_W-1:0]    out_avg_raw;
  logic                 out_image_present;

  deframe_scoreboard sb;
  logic        idle_en = 1'b1;
  int unsigned out_hold = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned cur_short;
  int unsigned cur_long;
  logic [BYTE_W-1:0] cur_stop;

  // Bad stop byte, then a header with a tiny length, then a good frame with
  // extreme words and the image flag set.
  logic [BYTE_W-1:0] directed_bytes [25] = '{
    8'hFF, 8'h00, 8'h0B, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h00, 8'h5A,
    8'hFF, 8'h00, 8'h05,
    8'hFF, 8'h00, 8'h0B, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h80, 8'h01, 8'h01, 8'h00
  };

  resync_frame_deframer_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_length  (out_frame_length),
    .out_min_raw       (out_min_raw),
    .out_max_raw       (out_max_raw),
    .out_avg_raw       (out_avg_raw),
    .out_image_present (out_image_present)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // The receiver stalls in random bursts, only while idle_en is set.
  always @(posedge clk) begin
    if (out_hold != 0) begin
      out_hold <= out_hold - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      out_hold  <= $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_result({out_frame_length, out_min_raw, out_max_raw, out_avg_raw,
                         out_image_present});
      end
      if (in_valid && !in_stall) sb.absorb_byte(in_data_byte);
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
    end
  end

  task send_byte(input logic [BYTE_W-1:0] b);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Sends the first cut bytes of a frame of len bytes whose header declares
  // len_field.
  task send_frame(input int unsigned len, input logic [LEN_W-1:0] len_field,
                  input bit good_stop, input int unsigned cut);
    logic [BYTE_W-1:0] b;
    int unsigned k;
    for (k = 0; k < cut; k++) begin
      if (k == 0) b = START_MARK;
      else if (k == 1) b = len_field[15:8];
      else if (k == 2) b = len_field[7:0];
      else if (k == len - 1) b = good_stop ? cur_stop : cur_stop ^ 8'($urandom_range(1, 255));
      else if (k == 9) b = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(1, 255));
      else b = 8'($urandom_range(0, 255));
      send_byte(b);
    end
  endtask

  task send_mix(input int unsigned budget);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 1) && cur_long <= MAX_MIX_LEN) ? cur_long : cur_short;
      if (pick < 70) send_frame(len, len[15:0], 1'b1, len);
      else if (pick < 78) send_frame(len, len[15:0], 1'b0, len);
      else if (pick < 85) send_frame(len, 16'($urandom_range(0, 65535)), 1'b1, len);
      else if (pick < 92) send_frame(len, len[15:0], 1'b1, $urandom_range(1, len - 1));
      else repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task apply_config(input int unsigned short_v, input int unsigned long_v,
                    input int unsigned stop_v, input bit poke_unused);
    logic [1:0]  idx [4];
    int unsigned val [4];
    int i;
    idx[0] = CFG_SHORT_LEN;  val[0] = short_v;
    idx[1] = CFG_UNUSED_IDX; val[1] = 11'h3FF;
    idx[2] = CFG_LONG_LEN;   val[2] = long_v;
    idx[3] = CFG_STOP;       val[3] = stop_v;
    for (i = 0; i < 4; i++) begin
      if (i == 1 && !poke_unused) continue;
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i][CFG_LEN_W-1:0];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    cur_short = short_v;
    cur_long  = long_v;
    cur_stop  = stop_v[BYTE_W-1:0];
  endtask

  // A byte may still be walking the store after the last frame word, so
  // the block gets a generous quiet spell before anything is reconfigured.
  task settle();
    in_valid <= 1'b0;
    while (sb.expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int p;
    sb = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    cur_short    = SHORT_RESET;
    cur_long     = LONG_RESET;
    cur_stop     = STOP_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    settle();

    apply_config(11, 11, 255, 1'b0);
    send_mix(MIX_BYTES);
    settle();

    // One long frame between short traffic, with a write to the unused index.
    apply_config($urandom_range(11, 40), $urandom_range(200, 300), 0, 1'b1);
    send_mix(40);
    send_frame(cur_long, cur_long[15:0], 1'b1, cur_long);
    send_mix(40);
    settle();

    for (p = 0; p < 3; p++) begin
      apply_config($urandom_range(11, 40),
                   (p == 1) ? $urandom_range(256, 1023) : $urandom_range(11, 64),
                   $urandom_range(0, 255), 1'b0);
      send_mix(MIX_BYTES);
      settle();
    end

    // Closing stretch runs back to back on both sides.
    idle_en <= 1'b0;
    apply_config($urandom_range(11, 40), $urandom_range(11, 64), $urandom_range(0, 255), 1'b0);
    send_mix(MIX_BYTES);
    settle();

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
